>>> design/tdf_pkg.sv
// Shared constants and state codes for the trial-division factorizer.
`default_nettype none
package tdf_pkg;
  localparam int unsigned ValueWidth = 32;
  // Candidates reach just past the square root of the widest value.
  localparam int unsigned CandWidth  = ValueWidth / 2 + 1;
  localparam int unsigned CntWidth   = $clog2(ValueWidth);

  typedef logic [ValueWidth-1:0] value_t;
  typedef logic [CandWidth-1:0]  cand_t;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StCheck = 2'd1;
  localparam logic [1:0] StDiv   = 2'd2;
  localparam logic [1:0] StEval  = 2'd3;
endpackage
`default_nettype wire

>>> design/trial_division_factorizer_unit.sv
// Top level of the trial-division factorizer with a shared restoring divider.
// An input below 2 gives its result in the cycle after it is taken.
// Otherwise each trial runs a check, 32 divider steps and an evaluate,
// so a 32-bit prime takes about 21846 trials.
// The block takes one item at a time; busy is high until the last result.
// Reset clears the sequencer and the strobe; the receiver cannot stall.
`default_nettype none
module trial_division_factorizer_unit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire tdf_pkg::value_t value_i,
  output logic                result_valid_o,
  output tdf_pkg::value_t     factor_o,
  output logic                no_factors_o,
  output logic                input_is_prime_o,
  output logic                last_o
);
  import tdf_pkg::*;

  logic [1:0]          state_q, state_d;
  value_t              orig_q, orig_d;
  value_t              rem_q, rem_d;
  cand_t               cand_q, cand_d;
  logic                phase_q, phase_d;
  logic                first_q, first_d;
  logic                prime_q, prime_d;
  value_t              dq_q, dq_d;
  logic [CandWidth-1:0] r_q, r_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                vld_q, vld_d;
  value_t              fac_q, fac_d;
  logic                nof_q, nof_d;
  logic                ipr_q, ipr_d;
  logic                last_q, last_d;

  logic [2*CandWidth-1:0] cand_sq;
  logic [CandWidth:0]     r_shift;
  logic                   emit;
  value_t                 emit_fac;
  logic                   emit_prime;

  assign cand_sq = cand_q * cand_q;
  assign r_shift = {r_q, dq_q[ValueWidth-1]};
  assign emit_prime = first_q ? (emit_fac == orig_q) : prime_q;

  always_comb begin
    state_d = state_q;
    orig_d  = orig_q;
    rem_d   = rem_q;
    cand_d  = cand_q;
    phase_d = phase_q;
    first_d = first_q;
    prime_d = prime_q;
    dq_d    = dq_q;
    r_d     = r_q;
    cnt_d   = cnt_q;
    vld_d   = 1'b0;
    fac_d   = fac_q;
    nof_d   = nof_q;
    ipr_d   = ipr_q;
    last_d  = last_q;
    emit     = 1'b0;
    emit_fac = rem_q;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          orig_d  = value_i;
          rem_d   = value_i;
          cand_d  = CandWidth'(2);
          phase_d = 1'b0;
          first_d = 1'b1;
          if (value_i < ValueWidth'(2)) begin
            vld_d  = 1'b1;
            fac_d  = '0;
            nof_d  = 1'b1;
            ipr_d  = 1'b0;
            last_d = 1'b1;
          end else begin
            state_d = StCheck;
          end
        end
      end
      StCheck: begin
        if (cand_q >= CandWidth'(5) &&
            cand_sq > {{(2*CandWidth-ValueWidth){1'b0}}, rem_q}) begin
          // No candidate up to the square root divides: the rest is prime.
          emit     = 1'b1;
          emit_fac = rem_q;
          last_d   = 1'b1;
          state_d  = StIdle;
        end else begin
          dq_d    = rem_q;
          r_d     = '0;
          cnt_d   = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (r_shift >= {1'b0, cand_q}) begin
          r_d = CandWidth'(r_shift - {1'b0, cand_q});
          dq_d = {dq_q[ValueWidth-2:0], 1'b1};
        end else begin
          r_d = r_shift[CandWidth-1:0];
          dq_d = {dq_q[ValueWidth-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntWidth'(ValueWidth-1)) state_d = StEval;
      end
      default: begin
        if (r_q == '0) begin
          emit     = 1'b1;
          emit_fac = {{(ValueWidth-CandWidth){1'b0}}, cand_q};
          last_d   = (dq_q == ValueWidth'(1));
          rem_d    = dq_q;
          state_d  = (dq_q == ValueWidth'(1)) ? StIdle : StCheck;
        end else begin
          // Candidates run 2, 3, then 5, 7, 11, 13, ... in steps of 2 and 4.
          if (cand_q == CandWidth'(2)) begin
            cand_d = CandWidth'(3);
          end else if (cand_q == CandWidth'(3)) begin
            cand_d  = CandWidth'(5);
            phase_d = 1'b0;
          end else begin
            cand_d  = cand_q + (phase_q ? CandWidth'(4) : CandWidth'(2));
            phase_d = ~phase_q;
          end
          state_d = StCheck;
        end
      end
    endcase
    if (emit) begin
      vld_d   = 1'b1;
      fac_d   = emit_fac;
      nof_d   = 1'b0;
      ipr_d   = emit_prime;
      prime_d = emit_prime;
      first_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    orig_q  <= orig_d;
    rem_q   <= rem_d;
    cand_q  <= cand_d;
    phase_q <= phase_d;
    first_q <= first_d;
    prime_q <= prime_d;
    dq_q    <= dq_d;
    r_q     <= r_d;
    cnt_q   <= cnt_d;
    fac_q   <= fac_d;
    nof_q   <= nof_d;
    ipr_q   <= ipr_d;
    last_q  <= last_d;
  end

  assign busy             = (state_q != StIdle);
  assign result_valid_o   = vld_q;
  assign factor_o         = fac_q;
  assign no_factors_o     = nof_q;
  assign input_is_prime_o = ipr_q;
  assign last_o           = last_q;

`ifndef ASSERT_OFF
  a_nof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && nof_q |-> last_q && fac_q == '0 && !ipr_q)
    else $error("empty factorization result malformed");
  a_fell_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> vld_q && last_q)
    else $error("item finished without a last result");
  a_busy_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && busy |-> !last_q)
    else $error("last result while still working");
  a_prime_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && ipr_q |-> last_q && fac_q == orig_q)
    else $error("prime input gave more than one factor");
`endif
endmodule
`default_nettype wire
